// ----- hw/rtl/wqtb_pkg.sv -----
// shared types, codes and constants of the write quota token bucket
package wqtb_pkg;

  localparam int unsigned TIME_W   = 63;
  localparam int unsigned SIZE_W   = 24;
  localparam int unsigned KEYS_W   = 16;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned TOK_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [15:0]         RST_MAX_VALUE_BYTES = 16'd4096;
  localparam logic [KEYS_W-1:0]   RST_MAX_KEYS        = 16'd64;
  localparam logic [SIZE_W-1:0]   RST_MAX_BYTES       = 24'd16384;
  localparam logic [PERIOD_W-1:0] RST_REFILL_PERIOD   = 32'd1000000;
  localparam logic [TOK_W-1:0]    RST_BURST_LIMIT     = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_VALUE_BYTES = 3'd0,
    REG_MAX_KEYS        = 3'd1,
    REG_MAX_BYTES       = 3'd2,
    REG_REFILL_PERIOD   = 3'd3,
    REG_BURST_LIMIT     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EXHAUSTED    = 3'd1,
    ST_INTERNAL     = 3'd2,
    ST_RATE_LIMITED = 3'd3,
    ST_NOT_FOUND    = 3'd4
  } status_t;

  typedef enum logic {
    OP_SET    = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    LK_FOUND     = 2'd0,
    LK_NOT_FOUND = 2'd1,
    LK_FAILURE   = 2'd2
  } lookup_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FIN  = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [15:0]         max_value_bytes;
    logic [KEYS_W-1:0]   max_keys;
    logic [SIZE_W-1:0]   max_bytes;
    logic [PERIOD_W-1:0] refill_period_us;
    logic [TOK_W-1:0]    burst_limit;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    status_t           status;
    logic              need_token;
    logic [TIME_W-1:0] now_us;
  } item_t;

endpackage

// ----- hw/rtl/wqtb_front.sv -----
// front end: takes requests and runs the quota checks
module wqtb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wqtb_pkg::cfg_t               cfg,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_opcode,
  input  logic [wqtb_pkg::TIME_W-1:0]  in_now_us,
  input  logic [wqtb_pkg::SIZE_W-1:0]  in_write_size,
  input  logic                         in_usage_ok,
  input  logic [wqtb_pkg::SIZE_W-1:0]  in_used_bytes,
  input  logic [wqtb_pkg::KEYS_W-1:0]  in_used_keys,
  input  logic [1:0]                   in_lookup_result,
  input  logic [wqtb_pkg::SIZE_W-1:0]  in_previous_size,
  output logic                         q_push,
  input  logic                         q_full,
  output wqtb_pkg::item_t              q_item
);
  import wqtb_pkg::*;

  logic               valid_r, valid_nxt;
  item_t              item_r;
  item_t              item_c;
  logic               accept;
  status_t            set_st;
  status_t            rm_st;
  logic [SIZE_W-1:0]  prev;
  logic [SIZE_W:0]    total;

  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r;
  assign q_item = item_r;

  always_comb begin
    prev   = '0;
    set_st = ST_OK;
    if (lookup_t'(in_lookup_result) == LK_FOUND) begin
      prev = in_previous_size;
    end
    // bytes after the old value is replaced by the new one
    total = {1'b0, in_used_bytes - prev} + {1'b0, in_write_size};
    priority if (in_write_size > {8'b0, cfg.max_value_bytes}) begin
      set_st = ST_EXHAUSTED;
    end else if (!in_usage_ok) begin
      set_st = ST_INTERNAL;
    end else if (lookup_t'(in_lookup_result) != LK_FOUND &&
                 lookup_t'(in_lookup_result) != LK_NOT_FOUND) begin
      set_st = ST_INTERNAL;
    end else if (lookup_t'(in_lookup_result) == LK_NOT_FOUND &&
                 in_used_keys >= cfg.max_keys) begin
      set_st = ST_EXHAUSTED;
    end else if (in_used_bytes < prev || total > {1'b0, cfg.max_bytes}) begin
      set_st = ST_EXHAUSTED;
    end else begin
      set_st = ST_OK;
    end
  end

  always_comb begin
    unique case (lookup_t'(in_lookup_result))
      LK_FOUND:     rm_st = ST_OK;
      LK_NOT_FOUND: rm_st = ST_NOT_FOUND;
      default:      rm_st = ST_INTERNAL;
    endcase
  end

  always_comb begin
    item_c.status     = (opcode_t'(in_opcode) == OP_SET) ? set_st : rm_st;
    item_c.need_token = (item_c.status == ST_OK);
    item_c.now_us     = in_now_us;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !q_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_c;
    end
  end

endmodule

// ----- hw/rtl/wqtb_queue.sv -----
// short queue of classified words between front and back
module wqtb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  wqtb_pkg::item_t wr_item,
  output logic            q_full,
  input  logic            rd_en,
  output wqtb_pkg::item_t rd_item,
  output logic            q_empty
);
  import wqtb_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign q_full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ----- hw/rtl/wqtb_bucket.sv -----
// back end: lazy token bucket refill with a serial divider, result register
module wqtb_bucket (
  input  logic            clk,
  input  logic            rst_n,
  input  wqtb_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  wqtb_pkg::item_t q_item,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic [2:0]      out_status
);
  import wqtb_pkg::*;

  bk_state_t            state_r, state_nxt;
  item_t                work_r;
  logic [TOK_W-1:0]     tokens_r, tokens_nxt;
  logic [TIME_W-1:0]    stamp_r, stamp_nxt;
  logic [TIME_W-1:0]    quo_r;
  logic [PERIOD_W-1:0]  rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 div_done_r;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;

  logic                 do_div;
  logic [PERIOD_W:0]    rem_sh;
  logic                 ge;
  logic                 refill;
  logic [TOK_W:0]       tok_sum;
  logic [TOK_W-1:0]     tok_ref;
  logic                 slot_free;
  logic                 fin_wr;
  status_t              fin_st;

  assign empty      = !out_valid_r;
  assign out_status = out_status_r;
  assign slot_free  = !out_valid_r || pop;

  // refill only needs dividing when time moved past the stamp
  assign do_div = q_item.need_token && (q_item.now_us > stamp_r) &&
                  (cfg.refill_period_us != '0);

  assign rem_sh = {rem_r, quo_r[TIME_W-1]};
  assign ge     = rem_sh >= {1'b0, cfg.refill_period_us};

  always_comb begin
    refill  = div_done_r && (quo_r != '0);
    tok_sum = {1'b0, tokens_r} + {1'b0, quo_r[TOK_W-1:0]};
    tok_ref = tokens_r;
    if (refill) begin
      if (|quo_r[TIME_W-1:TOK_W] || tok_sum >= {1'b0, cfg.burst_limit}) begin
        tok_ref = cfg.burst_limit;
      end else begin
        tok_ref = tok_sum[TOK_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    fin_wr     = 1'b0;
    fin_st     = work_r.status;
    tokens_nxt = tokens_r;
    stamp_nxt  = stamp_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = do_div ? BK_DIV : BK_FIN;
        end
      end
      BK_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (work_r.need_token && tok_ref == '0) begin
          fin_st = ST_RATE_LIMITED;
        end
        if (slot_free) begin
          fin_wr    = 1'b1;
          state_nxt = BK_IDLE;
          if (work_r.need_token) begin
            tokens_nxt = (tok_ref == '0) ? tok_ref : tok_ref - 1'b1;
            // stamp plus whole periods equals now minus the remainder
            if (refill) begin
              stamp_nxt = work_r.now_us - {31'b0, rem_r};
            end
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_wr) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      tokens_r    <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
      div_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tokens_r    <= tokens_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        div_done_r <= do_div;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_item;
      quo_r  <= q_item.now_us - stamp_r;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (state_r == BK_DIV) begin
      quo_r <= {quo_r[TIME_W-2:0], ge};
      rem_r <= ge ? PERIOD_W'(rem_sh - {1'b0, cfg.refill_period_us})
                  : rem_sh[PERIOD_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
    if (fin_wr) begin
      out_status_r <= fin_st;
    end
  end

endmodule

// ----- hw/rtl/write_quota_token_bucket.sv -----
// Admission controller for key-value writes: a front end checks each request against the
// value-size, key-count and byte quotas and the lookup result, a four-word queue decouples it
// from the back end, which refills a token bucket by whole elapsed periods and draws one token
// per passing request. Requests enter through push/full and statuses leave through empty/pop.
// A request that passes its checks and reaches the bucket with time past the refill stamp and
// a nonzero refill period goes through the back end's 63-step one-bit-per-cycle divide of
// elapsed time by the refill period before its finish step; any other request goes straight to
// the finish step, and the back end holds there while an unpopped status occupies the result
// register. Configuration writes are taken every cycle and belong to idle periods only.
module write_quota_token_bucket (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_opcode,
  input  logic [wqtb_pkg::TIME_W-1:0]      in_now_us,
  input  logic [wqtb_pkg::SIZE_W-1:0]      in_write_size,
  input  logic                             in_usage_ok,
  input  logic [wqtb_pkg::SIZE_W-1:0]      in_used_bytes,
  input  logic [wqtb_pkg::KEYS_W-1:0]      in_used_keys,
  input  logic [1:0]                       in_lookup_result,
  input  logic [wqtb_pkg::SIZE_W-1:0]      in_previous_size,
  output logic                             empty,
  input  logic                             pop,
  output logic [2:0]                       out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wqtb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wqtb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wqtb_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_wr_item, q_rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_value_bytes  <= RST_MAX_VALUE_BYTES;
      cfg_r.max_keys         <= RST_MAX_KEYS;
      cfg_r.max_bytes        <= RST_MAX_BYTES;
      cfg_r.refill_period_us <= RST_REFILL_PERIOD;
      cfg_r.burst_limit      <= RST_BURST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_VALUE_BYTES: cfg_r.max_value_bytes  <= cfg_data[15:0];
        REG_MAX_KEYS:        cfg_r.max_keys         <= cfg_data[KEYS_W-1:0];
        REG_MAX_BYTES:       cfg_r.max_bytes        <= cfg_data[SIZE_W-1:0];
        REG_REFILL_PERIOD:   cfg_r.refill_period_us <= cfg_data[PERIOD_W-1:0];
        REG_BURST_LIMIT:     cfg_r.burst_limit      <= cfg_data[TOK_W-1:0];
        default: ;
      endcase
    end
  end

  wqtb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_now_us        (in_now_us),
    .in_write_size    (in_write_size),
    .in_usage_ok      (in_usage_ok),
    .in_used_bytes    (in_used_bytes),
    .in_used_keys     (in_used_keys),
    .in_lookup_result (in_lookup_result),
    .in_previous_size (in_previous_size),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_item           (q_wr_item)
  );

  wqtb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (q_rd_item),
    .q_empty (q_empty)
  );

  wqtb_bucket u_bucket (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_status (out_status)
  );

endmodule
